[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros
// shared shorthand for clocked implication checks
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define NTWT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define NTWT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

[hw/rtl/ntwt_pkg.sv]
// ---------------------------------------------------------------------------
// ntwt_pkg
// shared types and constants of the number-to-word token block
// ---------------------------------------------------------------------------
package ntwt_pkg;

   localparam int VALUE_W   = 40;
   localparam int WORD_W    = 6;
   localparam int DIGIT_W   = 4;
   localparam int NUM_DIGIT = 12;
   localparam int BCD_W     = NUM_DIGIT * DIGIT_W;
   localparam int GROUP_W   = 3 * DIGIT_W;
   localparam int GRP_IDX_W = 2;
   localparam int CNT_W     = 6;

   localparam logic [VALUE_W-1:0] VALUE_LIMIT = 40'd999999999999;
   localparam logic [CNT_W-1:0]   CONV_CYCLES = CNT_W'(VALUE_W);

   // word codes
   localparam logic [WORD_W-1:0] W_ZERO     = 6'd0;
   localparam logic [WORD_W-1:0] W_TWENTY   = 6'd20;
   localparam logic [WORD_W-1:0] W_NINETY   = 6'd27;
   localparam logic [WORD_W-1:0] W_HUNDRED  = 6'd28;
   localparam logic [WORD_W-1:0] W_AND      = 6'd29;
   localparam logic [WORD_W-1:0] W_THOUSAND = 6'd30;
   localparam logic [WORD_W-1:0] W_MILLION  = 6'd31;
   localparam logic [WORD_W-1:0] W_BILLION  = 6'd32;

   // three-digit groups, most significant first
   localparam logic [GRP_IDX_W-1:0] GRP_BILLION  = 2'd0;
   localparam logic [GRP_IDX_W-1:0] GRP_MILLION  = 2'd1;
   localparam logic [GRP_IDX_W-1:0] GRP_THOUSAND = 2'd2;
   localparam logic [GRP_IDX_W-1:0] GRP_UNITS    = 2'd3;

   typedef enum logic [2:0] {
      TOK_HDIG,
      TOK_HUND,
      TOK_AND,
      TOK_TENS,
      TOK_UNITS,
      TOK_SCALE,
      TOK_ZERO,
      TOK_ERR
   } tok_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CONV,
      ST_SEEK,
      ST_HDIG,
      ST_HUND,
      ST_AND,
      ST_LOW,
      ST_UNITS,
      ST_SCALE,
      ST_ZERO,
      ST_ERR
   } state_type;

   typedef struct packed {
      logic         load;
      logic         shift;
      logic         next_grp;
      logic         emit;
      tok_kind_type kind;
      logic         last;
   } dp_cmd_type;

   typedef struct packed {
      logic conv_done;
      logic oor;
      logic val_zero;
      logic grp_nz;
      logic is_units;
      logic rest_zero;
      logic h_nz;
      logic r_nz;
      logic t_ge2;
      logic u_nz;
      logic out_free;
   } dp_status_type;

endpackage

[hw/rtl/ntwt_ctrl.sv]
// ---------------------------------------------------------------------------
// ntwt_ctrl
// sequencer: conversion, group walk and token emission order
// ---------------------------------------------------------------------------
module ntwt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  ntwt_pkg::dp_status_type sts,
   output ntwt_pkg::dp_cmd_type    cmd
);
   import ntwt_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      group_end;

   // after the units word of a group: scale word, or done in the units group
   assign group_end = sts.is_units;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_CONV;
         end
         ST_CONV: begin
            if (sts.conv_done) begin
               if (sts.oor)           state_in = ST_ERR;
               else if (sts.val_zero) state_in = ST_ZERO;
               else                   state_in = ST_SEEK;
            end
         end
         ST_SEEK: begin
            if (sts.grp_nz) state_in = sts.h_nz ? ST_HDIG : ST_LOW;
         end
         ST_HDIG: begin
            if (sts.out_free) state_in = ST_HUND;
         end
         ST_HUND: begin
            if (sts.out_free) begin
               if (sts.r_nz)       state_in = ST_AND;
               else if (group_end) state_in = ST_IDLE;
               else                state_in = ST_SCALE;
            end
         end
         ST_AND: begin
            if (sts.out_free) state_in = ST_LOW;
         end
         ST_LOW: begin
            if (sts.out_free) begin
               if (sts.t_ge2 && sts.u_nz) state_in = ST_UNITS;
               else if (group_end)        state_in = ST_IDLE;
               else                       state_in = ST_SCALE;
            end
         end
         ST_UNITS: begin
            if (sts.out_free) state_in = group_end ? ST_IDLE : ST_SCALE;
         end
         ST_SCALE: begin
            if (sts.out_free) state_in = sts.rest_zero ? ST_IDLE : ST_SEEK;
         end
         ST_ZERO, ST_ERR: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      cmd          = '0;
      cmd.kind     = TOK_ZERO;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_CONV: begin
            cmd.shift = !sts.conv_done;
         end
         ST_SEEK: begin
            cmd.next_grp = !sts.grp_nz;
         end
         ST_HDIG: begin
            cmd.emit = sts.out_free;
            cmd.kind = TOK_HDIG;
         end
         ST_HUND: begin
            cmd.emit = sts.out_free;
            cmd.kind = TOK_HUND;
            cmd.last = group_end && !sts.r_nz;
         end
         ST_AND: begin
            cmd.emit = sts.out_free;
            cmd.kind = TOK_AND;
         end
         ST_LOW: begin
            cmd.emit = sts.out_free;
            if (sts.t_ge2) begin
               cmd.kind = TOK_TENS;
               cmd.last = group_end && !sts.u_nz;
            end else begin
               cmd.kind = TOK_UNITS;
               cmd.last = group_end;
            end
         end
         ST_UNITS: begin
            cmd.emit = sts.out_free;
            cmd.kind = TOK_UNITS;
            cmd.last = group_end;
         end
         ST_SCALE: begin
            cmd.emit     = sts.out_free;
            cmd.kind     = TOK_SCALE;
            cmd.last     = sts.rest_zero;
            cmd.next_grp = sts.out_free && !sts.rest_zero;
         end
         ST_ZERO: begin
            cmd.emit = sts.out_free;
            cmd.kind = TOK_ZERO;
            cmd.last = 1'b1;
         end
         ST_ERR: begin
            cmd.emit = sts.out_free;
            cmd.kind = TOK_ERR;
            cmd.last = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hw/rtl/ntwt_dp.sv]
// ---------------------------------------------------------------------------
// ntwt_dp
// datapath: bit-serial binary to bcd, group digit select, token register
// ---------------------------------------------------------------------------
module ntwt_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [ntwt_pkg::VALUE_W-1:0]      req_value,
   input  ntwt_pkg::dp_cmd_type              cmd,
   output ntwt_pkg::dp_status_type           sts,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [ntwt_pkg::WORD_W-1:0]       rsp_word,
   output logic                              rsp_hyphen,
   output logic                              rsp_last,
   output logic                              rsp_oor
);
   import ntwt_pkg::*;

   logic [VALUE_W-1:0]   bin_ff,   bin_in;
   logic [BCD_W-1:0]     bcd_ff,   bcd_in;
   logic [CNT_W-1:0]     cnt_ff,   cnt_in;
   logic [GRP_IDX_W-1:0] grp_ff,   grp_in;
   logic                 oor_ff,   oor_in;
   logic                 valid_ff, valid_in;
   logic [WORD_W-1:0]    word_ff,  word_in;
   logic                 hyph_ff,  hyph_in;
   logic                 last_ff,  last_in;
   logic                 eoor_ff,  eoor_in;

   logic [BCD_W-1:0]     adj;
   logic [GROUP_W-1:0]   grp_dig;
   logic [DIGIT_W-1:0]   h, t, u;
   logic                 rest_zero;
   logic [WORD_W-1:0]    tok_word;
   logic                 out_free;

   // add-3 correction on every digit before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGIT; i++) begin
         if (bcd_ff[i*DIGIT_W +: DIGIT_W] >= 4'd5)
            adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W] + 4'd3;
         else
            adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W];
      end
   end

   // current group digits and whether all lower groups are zero
   always_comb begin
      case (grp_ff)
         GRP_BILLION: begin
            grp_dig   = bcd_ff[4*GROUP_W-1 -: GROUP_W];
            rest_zero = (bcd_ff[3*GROUP_W-1:0] == '0);
         end
         GRP_MILLION: begin
            grp_dig   = bcd_ff[3*GROUP_W-1 -: GROUP_W];
            rest_zero = (bcd_ff[2*GROUP_W-1:0] == '0);
         end
         GRP_THOUSAND: begin
            grp_dig   = bcd_ff[2*GROUP_W-1 -: GROUP_W];
            rest_zero = (bcd_ff[GROUP_W-1:0] == '0);
         end
         default: begin
            grp_dig   = bcd_ff[GROUP_W-1:0];
            rest_zero = 1'b1;
         end
      endcase
   end

   assign h = grp_dig[3*DIGIT_W-1 -: DIGIT_W];
   assign t = grp_dig[2*DIGIT_W-1 -: DIGIT_W];
   assign u = grp_dig[DIGIT_W-1:0];

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      sts.conv_done = (cnt_ff == '0);
      sts.oor       = oor_ff;
      sts.val_zero  = (bcd_ff == '0);
      sts.grp_nz    = (grp_dig != '0);
      sts.is_units  = (grp_ff == GRP_UNITS);
      sts.rest_zero = rest_zero;
      sts.h_nz      = (h != '0);
      sts.r_nz      = (t != '0) || (u != '0);
      sts.t_ge2     = (t[DIGIT_W-1:1] != '0);
      sts.u_nz      = (u != '0);
      sts.out_free  = out_free;
   end

   // word code for the token kind
   always_comb begin
      case (cmd.kind)
         TOK_HDIG:  tok_word = {2'b00, h};
         TOK_HUND:  tok_word = W_HUNDRED;
         TOK_AND:   tok_word = W_AND;
         TOK_TENS:  tok_word = W_TWENTY + {2'b00, t} - 6'd2;
         TOK_UNITS: begin
            if (sts.t_ge2) tok_word = {2'b00, u};
            else tok_word = ({2'b00, t} << 3) + ({2'b00, t} << 1) + {2'b00, u};
         end
         TOK_SCALE: tok_word = W_BILLION - {4'b0000, grp_ff};
         default:   tok_word = W_ZERO;
      endcase
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      cnt_in = cnt_ff;
      grp_in = grp_ff;
      oor_in = oor_ff;
      if (cmd.load) begin
         bin_in = req_value;
         bcd_in = '0;
         cnt_in = CONV_CYCLES;
         grp_in = GRP_BILLION;
         oor_in = (req_value > VALUE_LIMIT);
      end else begin
         if (cmd.shift) begin
            bin_in = {bin_ff[VALUE_W-2:0], 1'b0};
            bcd_in = {adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
            cnt_in = cnt_ff - CNT_W'(1);
         end
         if (cmd.next_grp) grp_in = grp_ff + GRP_IDX_W'(1);
      end
   end

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      word_in  = word_ff;
      hyph_in  = hyph_ff;
      last_in  = last_ff;
      eoor_in  = eoor_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
         word_in  = tok_word;
         hyph_in  = (cmd.kind == TOK_TENS) && sts.u_nz;
         last_in  = cmd.last;
         eoor_in  = (cmd.kind == TOK_ERR);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         grp_ff   <= GRP_BILLION;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         grp_ff   <= grp_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      oor_ff  <= oor_in;
      word_ff <= word_in;
      hyph_ff <= hyph_in;
      last_ff <= last_in;
      eoor_ff <= eoor_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_word   = word_ff;
   assign rsp_hyphen = hyph_ff;
   assign rsp_last   = last_ff;
   assign rsp_oor    = eoor_ff;

endmodule

[hw/rtl/number_to_word_tokens_top.sv]
// ---------------------------------------------------------------------------
// number_to_word_tokens_top
// spells an unsigned number in english as a run of word-token beats
// ---------------------------------------------------------------------------
// one 40-bit value is taken per request beat and answered by a run of
// response beats, one word token each, with tlast on the final token; a
// value above 999999999999 gives one beat with tuser set and word zero.
// an item is accepted, then converted from binary to bcd bit-serially
// (one input bit per cycle through the add-3 shift register), then the
// finished conversion is branched on; then the tokens (1 to 23) are
// emitted with a group seek for each three-digit group visited (none
// for zero or an error, up to 4); token emission waits while the
// response side stalls. one item is in work at a time; the final token
// sits in the response register while the next value is already taken.
module number_to_word_tokens_top (
   input  logic        clock,
   input  logic        reset,
   // request side
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [39:0] value
   // response side
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [5:0] word, [6] hyphen_follows, [7] zero
   output logic        rsp_tlast,   // last_word
   output logic        rsp_tuser    // [0] out_of_range
);
   import ntwt_pkg::*;

   dp_cmd_type        cmd;
   dp_status_type     sts;
   logic [WORD_W-1:0] rsp_word;
   logic              rsp_hyphen;

   // state machine: walks groups and picks the next token kind
   ntwt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // conversion registers, digit select and the response register
   ntwt_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_value  (req_tdata[VALUE_W-1:0]),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_word   (rsp_word),
      .rsp_hyphen (rsp_hyphen),
      .rsp_last   (rsp_tlast),
      .rsp_oor    (rsp_tuser)
   );

   // pack word and hyphen flag, pad to a whole byte
   assign rsp_tdata = {1'b0, rsp_hyphen, rsp_word};

endmodule

[hw/rtl/ntwt_checker.sv]
// ---------------------------------------------------------------------------
// ntwt_checker
// port-level checks of the number-to-word token block
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ntwt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);
   import ntwt_pkg::*;

   // a stalled response beat holds
   `NTWT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))

   // error beat is a lone zero word that closes the run
   `NTWT_ASSERT_IMPLY(a_err_beat, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast && (rsp_tdata[5:0] == W_ZERO) && !rsp_tdata[6])

   // hyphen only on a tens word, and a units word always follows
   `NTWT_ASSERT_IMPLY(a_hyphen, clock, reset, rsp_tvalid && rsp_tdata[6], !rsp_tlast && (rsp_tdata[5:0] >= W_TWENTY) && (rsp_tdata[5:0] <= W_NINETY))

   // word codes stay in range and the pad bit is zero
   `NTWT_ASSERT_IMPLY(a_word_range, clock, reset, rsp_tvalid, (rsp_tdata[5:0] <= W_BILLION) && !rsp_tdata[7])

   // one value in work at a time
   `NTWT_ASSERT_NEXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

bind number_to_word_tokens_top ntwt_checker u_ntwt_checker (.*);
